// ===== rtl/grid_ray_cast_dda_assert.svh =====
// Assertion macros used by the checker file of the grid ray caster.
// Depends on nothing; included by bare file name.
`ifndef GRID_RAY_CAST_DDA_ASSERT_SVH
`define GRID_RAY_CAST_DDA_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define GRD_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grid ray cast check failed");

// Next-cycle implication, disabled while reset is high.
`define GRD_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grid ray cast check failed");

`endif

// ===== rtl/grd_pkg.sv =====
// Package of the grid ray caster: constants, codes, state and struct types.
// Depends on nothing; used by every other file of the block but the assertion header.
`default_nettype none

package grd_pkg;

  // Map store and walk limits.
  localparam int MAP_CELLS = 4096;
  localparam int ADDR_W    = $clog2(MAP_CELLS);
  localparam int MAX_STEPS = 128;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int FRAC_BITS = 16;

  // Field widths.
  localparam int OP_W     = 1;
  localparam int CELL_W   = 12;
  localparam int TILE_W   = 8;
  localparam int COL_W    = 12;
  localparam int POS_W    = 22;
  localparam int DIR_W    = 19;
  localparam int DIST_W   = 24;
  localparam int TEXU_W   = 16;
  localparam int HEIGHT_W = 16;
  localparam int TEX_W    = 2;
  localparam int FAULT_W  = 2;
  localparam int MAP_W    = 7;
  localparam int SCR_W    = 12;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;

  // Walk datapath widths.
  localparam int NEXT_W  = 32;              // accumulated side distance
  localparam int GRID_W  = 9;               // signed cell coordinate
  localparam int ROW_W   = 10;              // signed row number
  localparam int LIN_W   = 2 * MAP_W;       // linear cell address before range check
  localparam int NUM_W   = 26;              // signed distance numerator
  localparam int TPROD_W = 32;              // low bits of the texture product

  // Shared divider.
  localparam int DIV_NUM_W = 40;
  localparam int DIV_DEN_W = 24;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic [DIST_W-1:0]   DIST_SAT   = '1;
  localparam logic [HEIGHT_W-1:0] HEIGHT_SAT = '1;
  localparam logic [DIV_NUM_W-1:0] ONE_SQUARED = DIV_NUM_W'(1) << (2 * FRAC_BITS);
  localparam logic [FRAC_BITS:0]  FRAC_ONE   = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  // Codes.
  localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OP_W-1:0] OP_CAST  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd2;

  localparam logic [MAP_W-1:0] MAP_WIDTH_RST     = 7'd64;
  localparam logic [MAP_W-1:0] MAP_HEIGHT_RST    = 7'd64;
  localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = 12'd480;

  localparam logic [FAULT_W-1:0] FAULT_HIT   = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_OUT   = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_LIMIT = 2'd2;

  localparam logic [TEX_W-1:0]  TEX_PLAIN    = 2'd1;
  localparam logic [TEX_W-1:0]  TEX_SPECIAL  = 2'd3;
  localparam logic [TILE_W-1:0] TILE_EMPTY   = 8'd0;
  localparam logic [TILE_W-1:0] TILE_SPECIAL = 8'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START_X,
    ST_WAIT_X,
    ST_WAIT_Y,
    ST_FIRST,
    ST_STEP,
    ST_CHECK,
    ST_TEST,
    ST_WAIT_DIST,
    ST_TEX,
    ST_WAIT_HEIGHT,
    ST_DONE
  } grd_state_t;

  typedef enum logic [1:0] {
    DIV_STEP_X,
    DIV_STEP_Y,
    DIV_DIST,
    DIV_HEIGHT
  } grd_div_sel_t;

  typedef struct packed {
    logic         capture;
    logic         tile_write;
    logic         div_start;
    grd_div_sel_t div_sel;
    logic         store_stx;
    logic         store_sty;
    logic         store_dist;
    logic         store_height;
    logic         first_load;
    logic         step;
    logic         check;
    logic         end_walk;
    logic         tex_mul;
    logic         emit;
  } grd_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_map;
    logic tile_hit;
    logic step_last;
  } grd_stat_t;

  typedef struct packed {
    logic [MAP_W-1:0] map_width;
    logic [MAP_W-1:0] map_height;
    logic [SCR_W-1:0] screen_height;
  } grd_cfg_t;

  typedef struct packed {
    logic [CELL_W-1:0]       cell_index;
    logic [TILE_W-1:0]       cell_value;
    logic [COL_W-1:0]        screen_column;
    logic [POS_W-1:0]        start_x;
    logic [POS_W-1:0]        start_y;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
  } grd_cast_t;

  typedef struct packed {
    logic [COL_W-1:0]    column_out;
    logic [DIST_W-1:0]   distance;
    logic                side_hit;
    logic [TEXU_W-1:0]   tex_u;
    logic [HEIGHT_W-1:0] wall_height;
    logic [TEX_W-1:0]    wall_texture;
    logic [FAULT_W-1:0]  walk_fault;
  } grd_res_t;

endpackage

`default_nettype wire

// ===== rtl/grd_if.sv =====
// Channel interfaces of the grid ray caster: request words in, result words out.
// Depends on grd_pkg for the field widths.
`default_nettype none

interface grd_req_if;
  import grd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [CELL_W-1:0]       cell_index;
  logic [TILE_W-1:0]       cell_value;
  logic [COL_W-1:0]        screen_column;
  logic [POS_W-1:0]        start_x;
  logic [POS_W-1:0]        start_y;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;

  modport source (output valid, operation, cell_index, cell_value, screen_column,
                  start_x, start_y, dir_x, dir_y, input ready);
  modport sink (input valid, operation, cell_index, cell_value, screen_column,
                start_x, start_y, dir_x, dir_y, output ready);
  modport monitor (input valid, ready, operation, cell_index, cell_value, screen_column,
                   start_x, start_y, dir_x, dir_y);
endinterface

interface grd_res_if;
  import grd_pkg::*;

  logic                valid;
  logic                ready;
  logic [COL_W-1:0]    column_out;
  logic [DIST_W-1:0]   distance;
  logic                side_hit;
  logic [TEXU_W-1:0]   tex_u;
  logic [HEIGHT_W-1:0] wall_height;
  logic [TEX_W-1:0]    wall_texture;
  logic [FAULT_W-1:0]  walk_fault;

  modport source (output valid, column_out, distance, side_hit, tex_u, wall_height,
                  wall_texture, walk_fault, input ready);
  modport sink (input valid, column_out, distance, side_hit, tex_u, wall_height,
                wall_texture, walk_fault, output ready);
  modport monitor (input valid, ready, column_out, distance, side_hit, tex_u,
                   wall_height, wall_texture, walk_fault);
endinterface

`default_nettype wire

// ===== rtl/grd_div.sv =====
// Radix-2 restoring divider shared by every division of the ray caster.
// Depends on grd_pkg; one quotient bit per cycle.
`default_nettype none

module grd_div (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [grd_pkg::DIV_NUM_W-1:0]    dividend,
  input  wire logic [grd_pkg::DIV_DEN_W-1:0]    divisor,
  output logic      [grd_pkg::DIV_NUM_W-1:0]    quotient,
  output logic                                  done
);
  import grd_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  // The dividend shifts out of quo at the top while quotient bits enter below.
  always_comb begin
    trial = {rem, quo[DIV_NUM_W-1]};
    fits  = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
      quo  <= dividend;
      den  <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], fits};
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = quo;
  assign done     = ~busy;

endmodule

`default_nettype wire

// ===== rtl/grd_dp.sv =====
// Datapath of the grid ray caster: tile store, step setup, grid walk and hit math.
// Depends on grd_pkg and grd_div; driven by commands from grd_ctrl.
`default_nettype none

module grd_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire grd_pkg::grd_cast_t cast,
  input  wire grd_pkg::grd_cfg_t  cfg,
  input  wire grd_pkg::grd_cmd_t  cmd,
  output grd_pkg::grd_stat_t      stat,
  output grd_pkg::grd_res_t       res
);
  import grd_pkg::*;

  logic [TILE_W-1:0] tiles [MAP_CELLS];

  logic [COL_W-1:0]         col;
  logic [POS_W-1:0]         sx, sy;
  logic signed [DIR_W-1:0]  dx, dy;
  logic [DIST_W-1:0]        stx, sty;
  logic [NEXT_W-1:0]        nx, ny;
  logic signed [GRID_W-1:0] cx, cy;
  logic                     side;
  logic [STEP_W-1:0]        cnt;
  logic                     out_map;
  logic [TILE_W-1:0]        rdata;
  logic [FAULT_W-1:0]       fault;
  logic [TEX_W-1:0]         texture;
  logic [DIST_W-1:0]        hit_dist;
  logic [TPROD_W-1:0]       tprod;
  logic [HEIGHT_W-1:0]      wh;

  logic [DIR_W-1:0]         dx_mag, dy_mag;
  logic [FRAC_BITS:0]       fx, fy;
  logic [FRAC_BITS+DIST_W:0] first_x, first_y;
  logic signed [ROW_W-1:0]  row;
  logic                     out_bounds;
  logic [LIN_W-1:0]         row_off;
  logic [LIN_W-1:0]         lin;
  logic                     out_now;

  logic signed [GRID_W-1:0] hit_cell;
  logic signed [DIR_W-1:0]  hit_d, other_d;
  logic [POS_W-1:0]         hit_pos, other_pos;
  logic signed [NUM_W-1:0]  cell_plus;
  logic signed [NUM_W-1:0]  num;
  logic [DIST_W-1:0]        num_mag;
  logic [DIR_W-1:0]         d_mag;
  logic signed [DIST_W+DIR_W:0] tex_full;
  logic [TPROD_W-1:0]       tex_sum;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic [DIV_NUM_W-1:0] div_q;
  logic                 div_done;
  logic                 hit;

  // Magnitudes of the directions; the most negative code gives 2^18.
  always_comb begin
    dx_mag = dx[DIR_W-1] ? (~dx + 1'b1) : dx;
    dy_mag = dy[DIR_W-1] ? (~dy + 1'b1) : dy;
  end

  // Distance to the first boundary: the fraction left in the start cell, scaled.
  always_comb begin
    fx = dx[DIR_W-1] ? {1'b0, sx[FRAC_BITS-1:0]} : FRAC_ONE - {1'b0, sx[FRAC_BITS-1:0]};
    fy = dy[DIR_W-1] ? {1'b0, sy[FRAC_BITS-1:0]} : FRAC_ONE - {1'b0, sy[FRAC_BITS-1:0]};
    first_x = fx * stx;
    first_y = fy * sty;
  end

  // Bounds and address of the current cell. Rows count down from the map height.
  always_comb begin
    row = $signed({3'b0, cfg.map_height}) - $signed({cy[GRID_W-1], cy});
    out_bounds = cx[GRID_W-1] || (cx >= $signed({2'b0, cfg.map_width})) ||
                 row[ROW_W-1] || (row >= $signed({3'b0, cfg.map_height}));
    row_off = row[MAP_W-1:0] * cfg.map_width;
    lin     = LIN_W'(cx[MAP_W-1:0]) + row_off;
    out_now = out_bounds || (lin >= LIN_W'(MAP_CELLS));
  end

  // Hit geometry on the side of the last step.
  always_comb begin
    hit_cell  = side ? cy : cx;
    hit_d     = side ? dy : dx;
    other_d   = side ? dx : dy;
    hit_pos   = side ? sy : sx;
    other_pos = side ? sx : sy;
    cell_plus = NUM_W'(hit_cell) + $signed({{(NUM_W-1){1'b0}}, hit_d[DIR_W-1]});
    num       = (cell_plus <<< FRAC_BITS) - $signed({{(NUM_W-POS_W){1'b0}}, hit_pos});
    num_mag   = num[NUM_W-1] ? DIST_W'(-num) : DIST_W'(num);
    d_mag     = hit_d[DIR_W-1] ? (~hit_d + 1'b1) : hit_d;
    tex_full  = $signed({1'b0, hit_dist}) * other_d;
    tex_sum   = {other_pos[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}} + tprod;
  end

  // Operand selection for the shared divider.
  always_comb begin
    div_start = cmd.div_start;
    unique case (cmd.div_sel)
      DIV_STEP_X: begin
        div_num = ONE_SQUARED;
        div_den = DIV_DEN_W'(dx_mag);
      end
      DIV_STEP_Y: begin
        div_num = ONE_SQUARED;
        div_den = DIV_DEN_W'(dy_mag);
      end
      DIV_DIST: begin
        div_num = DIV_NUM_W'({num_mag, {FRAC_BITS{1'b0}}});
        div_den = DIV_DEN_W'(d_mag);
      end
      DIV_HEIGHT: begin
        div_num = DIV_NUM_W'({cfg.screen_height, {FRAC_BITS{1'b0}}});
        div_den = hit_dist;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  grd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .quotient (div_q),
    .done     (div_done)
  );

  // Tile store: written by write words, read once per walk step.
  always_ff @(posedge clk) begin
    if (cmd.tile_write) begin
      tiles[cast.cell_index] <= cast.cell_value;
    end
    if (cmd.check) begin
      rdata <= tiles[lin[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col <= cast.screen_column;
      sx  <= cast.start_x;
      sy  <= cast.start_y;
      dx  <= cast.dir_x;
      dy  <= cast.dir_y;
      cx  <= $signed(GRID_W'(cast.start_x[POS_W-1:FRAC_BITS]));
      cy  <= $signed(GRID_W'(cast.start_y[POS_W-1:FRAC_BITS]));
    end
    if (cmd.store_stx) begin
      stx <= (div_q > DIV_NUM_W'(DIST_SAT)) ? DIST_SAT : div_q[DIST_W-1:0];
    end
    if (cmd.store_sty) begin
      sty <= (div_q > DIV_NUM_W'(DIST_SAT)) ? DIST_SAT : div_q[DIST_W-1:0];
    end
    if (cmd.first_load) begin
      nx  <= NEXT_W'(first_x[FRAC_BITS+DIST_W:FRAC_BITS]);
      ny  <= NEXT_W'(first_y[FRAC_BITS+DIST_W:FRAC_BITS]);
      cnt <= '0;
    end
    // Ties step in y.
    if (cmd.step) begin
      if (nx < ny) begin
        nx   <= nx + NEXT_W'(stx);
        cx   <= dx[DIR_W-1] ? cx - 1'b1 : cx + 1'b1;
        side <= 1'b0;
      end else begin
        ny   <= ny + NEXT_W'(sty);
        cy   <= dy[DIR_W-1] ? cy - 1'b1 : cy + 1'b1;
        side <= 1'b1;
      end
      cnt <= cnt + 1'b1;
    end
    if (cmd.check) begin
      out_map <= out_now;
    end
    if (cmd.end_walk) begin
      fault   <= out_map ? FAULT_OUT : ((rdata != TILE_EMPTY) ? FAULT_HIT : FAULT_LIMIT);
      texture <= (rdata == TILE_SPECIAL) ? TEX_SPECIAL : TEX_PLAIN;
    end
    // A zero direction saturates; a quotient of opposite sign clamps to zero.
    if (cmd.store_dist) begin
      if (d_mag == '0) begin
        hit_dist <= DIST_SAT;
      end else if (num[NUM_W-1] != hit_d[DIR_W-1]) begin
        hit_dist <= '0;
      end else begin
        hit_dist <= (div_q > DIV_NUM_W'(DIST_SAT)) ? DIST_SAT : div_q[DIST_W-1:0];
      end
    end
    if (cmd.tex_mul) begin
      tprod <= tex_full[TPROD_W-1:0];
    end
    if (cmd.store_height) begin
      wh <= (div_q > DIV_NUM_W'(HEIGHT_SAT)) ? HEIGHT_SAT : div_q[HEIGHT_W-1:0];
    end
  end

  always_comb begin
    hit            = (fault == FAULT_HIT);
    stat.div_done  = div_done;
    stat.out_map   = out_map;
    stat.tile_hit  = (rdata != TILE_EMPTY);
    stat.step_last = (cnt == STEP_W'(MAX_STEPS));

    res.column_out   = col;
    res.distance     = hit ? hit_dist : DIST_SAT;
    res.side_hit     = side;
    res.tex_u        = hit ? tex_sum[TPROD_W-1:FRAC_BITS] : '0;
    res.wall_height  = hit ? wh : '0;
    res.wall_texture = hit ? texture : TEX_PLAIN;
    res.walk_fault   = fault;
  end

endmodule

`default_nettype wire

// ===== rtl/grd_ctrl.sv =====
// Controller of the grid ray caster: sequences setup divisions, the walk and the hit math.
// Depends on grd_pkg; talks to grd_dp through command and status structs.
`default_nettype none

module grd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire logic               req_op,
  output logic                    req_ready,
  input  wire logic               out_free,
  input  wire grd_pkg::grd_stat_t stat,
  output grd_pkg::grd_cmd_t       cmd
);
  import grd_pkg::*;

  grd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_op == OP_CAST) begin
            cmd.capture = 1'b1;
            state_next  = ST_START_X;
          end else begin
            cmd.tile_write = 1'b1;
          end
        end
      end
      ST_START_X: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_STEP_X;
        state_next    = ST_WAIT_X;
      end
      ST_WAIT_X: begin
        if (stat.div_done) begin
          cmd.store_stx = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_STEP_Y;
          state_next    = ST_WAIT_Y;
        end
      end
      ST_WAIT_Y: begin
        if (stat.div_done) begin
          cmd.store_sty = 1'b1;
          state_next    = ST_FIRST;
        end
      end
      ST_FIRST: begin
        cmd.first_load = 1'b1;
        state_next     = ST_STEP;
      end
      ST_STEP: begin
        cmd.step   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = ST_TEST;
      end
      ST_TEST: begin
        if (stat.out_map || stat.tile_hit || stat.step_last) begin
          cmd.end_walk = 1'b1;
          if (!stat.out_map && stat.tile_hit) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_DIST;
            state_next    = ST_WAIT_DIST;
          end else begin
            state_next = ST_DONE;
          end
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_WAIT_DIST: begin
        if (stat.div_done) begin
          cmd.store_dist = 1'b1;
          state_next     = ST_TEX;
        end
      end
      ST_TEX: begin
        cmd.tex_mul   = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_HEIGHT;
        state_next    = ST_WAIT_HEIGHT;
      end
      ST_WAIT_HEIGHT: begin
        if (stat.div_done) begin
          cmd.store_height = 1'b1;
          state_next       = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/grid_ray_cast_dda.sv =====
// Top level of the grid ray caster: configuration registers, output register, glue.
// Depends on grd_pkg, grd_if, grd_ctrl and grd_dp.
`default_nettype none

// The block holds a 4096-entry tile map and casts rays through it with a grid DDA.
// A request word with operation 0 writes one tile and gives no result. A request
// word with operation 1 casts one ray and gives exactly one result word. A cast
// runs the step-size divisions for x and y, then walks from cell to cell, where the
// number of cells walked is 1 to 128; a walk that hits a wall then runs the hit
// distance division, the texture product and the wall height division. The single
// shared restoring divider serves all four divisions (two step sizes, the hit
// distance and the wall height), and each of them holds the controller until the
// quotient is ready; each walk step passes through a stepping state, a tile store
// read state and a test state. A walk that leaves the map or reaches the step limit
// skips the two hit divisions and the texture state. Only one cast is in flight at a
// time; the result sits in an output register, so the next request word is taken
// while a finished result still waits.
// The tile store has no reset: every cell a ray may reach must be written first.
// Configuration writes (map width, map height, screen height) take effect at once and
// are meant for times when no cast is in flight.

module grid_ray_cast_dda (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [grd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [grd_pkg::CFG_W-1:0]     cfg_data,
  grd_req_if.sink                            request,
  grd_res_if.source                          result
);
  import grd_pkg::*;

  grd_cfg_t  cfg;
  grd_cast_t cast;
  grd_cmd_t  cmd;
  grd_stat_t stat;
  grd_res_t  res_now;
  grd_res_t  res_reg;
  logic      res_valid;
  logic      out_free;

  // Configuration registers; a write to an unused index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_width     <= MAP_WIDTH_RST;
      cfg.map_height    <= MAP_HEIGHT_RST;
      cfg.screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:     cfg.map_width     <= cfg_data[MAP_W-1:0];
        REG_MAP_HEIGHT:    cfg.map_height    <= cfg_data[MAP_W-1:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[SCR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The request payload is gathered into one struct for the datapath.
  always_comb begin
    cast.cell_index    = request.cell_index;
    cast.cell_value    = request.cell_value;
    cast.screen_column = request.screen_column;
    cast.start_x       = request.start_x;
    cast.start_y       = request.start_y;
    cast.dir_x         = request.dir_x;
    cast.dir_y         = request.dir_y;
  end

  // The controller may hand over a finished word whenever the output register is
  // empty or is being emptied in the same cycle.
  assign out_free = !res_valid || result.ready;

  grd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_op    (request.operation),
    .req_ready (request.ready),
    .out_free  (out_free),
    .stat      (stat),
    .cmd       (cmd)
  );

  grd_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cast (cast),
    .cfg  (cfg),
    .cmd  (cmd),
    .stat (stat),
    .res  (res_now)
  );

  // Output register: holds one result word until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_reg <= res_now;
    end
  end

  always_comb begin
    result.valid        = res_valid;
    result.column_out   = res_reg.column_out;
    result.distance     = res_reg.distance;
    result.side_hit     = res_reg.side_hit;
    result.tex_u        = res_reg.tex_u;
    result.wall_height  = res_reg.wall_height;
    result.wall_texture = res_reg.wall_texture;
    result.walk_fault   = res_reg.walk_fault;
  end

endmodule

`default_nettype wire

// ===== rtl/grd_check.sv =====
// Port-level checker of the grid ray caster, bound to the top level.
// Depends on grd_pkg, grd_if and the macros of grid_ray_cast_dda_assert.svh.
`default_nettype none

`include "grid_ray_cast_dda_assert.svh"

module grd_check (
  input wire logic  clk,
  input wire logic  rst,
  grd_req_if.sink   request,
  grd_res_if.source result
);
  import grd_pkg::*;

  // A stalled result word holds.
  `GRD_ASSERT_NXT(a_res_hold, clk, rst, result.valid && !result.ready, result.valid && $stable(result.distance) && $stable(result.column_out))

  // A walk that ends without a hit reports no wall.
  `GRD_ASSERT_IMP(a_fault_fields, clk, rst, result.valid && (result.walk_fault != FAULT_HIT), (result.distance == DIST_SAT) && (result.wall_height == '0) && (result.tex_u == '0) && (result.wall_texture == TEX_PLAIN))

  // A hit at zero distance gives the tallest wall.
  `GRD_ASSERT_IMP(a_zero_dist, clk, rst, result.valid && (result.walk_fault == FAULT_HIT) && (result.distance == '0), result.wall_height == HEIGHT_SAT)

  // No result word appears in the cycle after a request word is taken.
  `GRD_ASSERT_NXT(a_no_instant, clk, rst, request.valid && request.ready, !$rose(result.valid))

endmodule

bind grid_ray_cast_dda grd_check u_check (
  .clk     (clk),
  .rst     (rst),
  .request (request),
  .result  (result)
);

`default_nettype wire
